[src/hpgm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hpgm_pkg;

  localparam int MAX_GESTURES = 64;
  localparam int FINGER_COUNT = 5;
  localparam int SPLAY_COUNT  = 4;
  localparam int SLOTS        = FINGER_COUNT + SPLAY_COUNT;
  localparam int VAL_W        = 8;
  localparam int SLOT_BITS    = 2 * VAL_W;
  localparam int ROW_W        = SLOTS * SLOT_BITS;
  localparam int ENTRY_W      = (MAX_GESTURES > 1) ? $clog2(MAX_GESTURES) : 1;
  localparam int CNT_W        = $clog2(MAX_GESTURES + 1);
  localparam int GIDX_W       = 6;

  localparam logic [1:0] CMD_WRITE    = 2'd0;
  localparam logic [1:0] CMD_VALIDATE = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;
  localparam logic [1:0] CMD_CLASSIFY = 2'd3;

  localparam logic [1:0] EV_UNCHANGED = 2'd0;
  localparam logic [1:0] EV_ENDED     = 2'd1;
  localparam logic [1:0] EV_STARTED   = 2'd2;

  typedef struct packed {
    logic [FINGER_COUNT*VAL_W-1:0] curls;
    logic [SPLAY_COUNT*VAL_W-1:0]  splays;
    logic                          has_splays;
  } pose_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [GIDX_W-1:0] idx;
    logic              hand;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

[src/hpgm_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none
module hpgm_cmp (
  input  wire logic [hpgm_pkg::ROW_W-1:0] row,
  input  wire hpgm_pkg::pose_t            pose,
  input  wire logic                       curl_only,
  output logic                            hit
);
  import hpgm_pkg::*;

  logic [SLOTS-1:0] ok;

  always_comb begin
    logic [SLOTS*VAL_W-1:0] vals;
    logic [VAL_W-1:0] v;
    logic [VAL_W-1:0] r;
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] d;
    vals = {pose.splays, pose.curls};
    for (int s = 0; s < SLOTS; s++) begin
      v = vals[s*VAL_W +: VAL_W];
      r = row[s*SLOT_BITS +: VAL_W];
      t = row[s*SLOT_BITS+VAL_W +: VAL_W];
      d = (v >= r) ? (v - r) : (r - v);
      ok[s] = (d <= t);
    end
    hit = (&ok[FINGER_COUNT-1:0]) &&
          (curl_only || !pose.has_splays || (&ok[SLOTS-1:FINGER_COUNT]));
  end

endmodule
`default_nettype wire

[src/hand_pose_gesture_matcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// Write, validate and clear items are handled without leaving the idle state.
// A classify item scans one template entry per cycle through the synchronously read
// template memory and stops early on a match; its results leave one at a time once
// the output side is free; the input stays blocked until the last result is loaded.
// Synchronous active-high reset clears the valid flags and per-hand tracking;
// template values are undefined until written.
module hand_pose_gesture_matcher (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // hand, curls_packed, splays_packed, has_splays, full_tracking, entry_index,
  // slot_index, slot_value, slot_tolerance, entry_curl_only, zero pad
  input  wire logic [103:0] s_axis_tdata,
  // command
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // gesture_index, event_hand, zero pad
  output logic [7:0]        m_axis_tdata,
  // event_kind
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  import hpgm_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic              in_hand;
  pose_t             in_pose;
  logic              in_full;
  logic [5:0]        in_entry;
  logic [3:0]        in_slot;
  logic [VAL_W-1:0]  in_value;
  logic [VAL_W-1:0]  in_tol;
  logic              in_curl_only;

  assign in_hand           = s_axis_tdata[0];
  assign in_pose.curls     = s_axis_tdata[40:1];
  assign in_pose.splays    = s_axis_tdata[72:41];
  assign in_pose.has_splays = s_axis_tdata[73];
  assign in_full           = s_axis_tdata[74];
  assign in_entry          = s_axis_tdata[80:75];
  assign in_slot           = s_axis_tdata[84:81];
  assign in_value          = s_axis_tdata[92:85];
  assign in_tol            = s_axis_tdata[100:93];
  assign in_curl_only      = s_axis_tdata[101];

  logic [1:0]              state;
  logic [CNT_W-1:0]        ptr;
  logic                    chk_live;
  logic [ENTRY_W-1:0]      chk_idx;
  logic [ROW_W-1:0]        row;
  pose_t                   pose;
  logic                    hand_r;
  logic                    full_r;
  logic                    any_valid_r;
  logic                    found;
  logic [ENTRY_W-1:0]      found_idx;
  logic [MAX_GESTURES-1:0] valid_flags;
  logic [MAX_GESTURES-1:0] curl_flags;
  logic [GIDX_W-1:0]       last_g [2];
  logic [1:0]              last_v;
  result_t                 q0;
  result_t                 q1;
  logic [1:0]              q_cnt;
  result_t                 out_r;
  logic [ROW_W-1:0]        mem [MAX_GESTURES];

  logic s_fire;
  logic hit;
  logic elig;
  logic entry_ok;
  logic out_load;
  logic lv;
  logic [GIDX_W-1:0] lg;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign entry_ok = int'(in_entry) < MAX_GESTURES;
  assign elig     = valid_flags[chk_idx] && (curl_flags[chk_idx] || full_r);
  assign out_load = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
  assign lv       = last_v[hand_r];
  assign lg       = last_g[hand_r];

  hpgm_cmp u_cmp (
    .row       (row),
    .pose      (pose),
    .curl_only (curl_flags[chk_idx]),
    .hit       (hit)
  );

  always_ff @(posedge clk) begin
    if (s_fire && s_axis_tuser == CMD_WRITE && entry_ok && int'(in_slot) < SLOTS) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (in_slot == 4'(s)) begin
          mem[ENTRY_W'(in_entry)][s*SLOT_BITS +: SLOT_BITS] <= {in_tol, in_value};
        end
      end
    end
    row <= mem[ptr[ENTRY_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_axis_tuser == CMD_VALIDATE && entry_ok) begin
      curl_flags[ENTRY_W'(in_entry)] <= in_curl_only;
    end
    if (s_fire && s_axis_tuser == CMD_CLASSIFY) begin
      pose   <= in_pose;
      hand_r <= in_hand;
      full_r <= in_full;
    end
    if (state == ST_SCAN) begin
      chk_idx <= ptr[ENTRY_W-1:0];
      if (chk_live && elig && hit) begin
        found_idx <= chk_idx;
      end
    end
    if (out_load) begin
      out_r <= q0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ptr           <= '0;
      chk_live      <= 1'b0;
      any_valid_r   <= 1'b0;
      found         <= 1'b0;
      valid_flags   <= '0;
      last_g[0]     <= '0;
      last_g[1]     <= '0;
      last_v        <= '0;
      q0            <= '0;
      q1            <= '0;
      q_cnt         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            case (s_axis_tuser)
              CMD_VALIDATE: begin
                if (entry_ok) begin
                  valid_flags[ENTRY_W'(in_entry)] <= 1'b1;
                end
              end
              CMD_CLEAR: begin
                valid_flags <= '0;
              end
              CMD_CLASSIFY: begin
                ptr         <= '0;
                chk_live    <= 1'b0;
                found       <= 1'b0;
                any_valid_r <= |valid_flags;
                state       <= (|valid_flags) ? ST_SCAN : ST_DECIDE;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          chk_live <= (int'(ptr) < MAX_GESTURES);
          if (int'(ptr) < MAX_GESTURES) begin
            ptr <= ptr + 1'b1;
          end
          if (chk_live && elig && hit) begin
            found <= 1'b1;
            state <= ST_DECIDE;
          end else if (!chk_live && int'(ptr) == MAX_GESTURES) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          state <= ST_EMIT;
          q_cnt <= 2'd1;
          if (!any_valid_r) begin
            q0 <= '{kind: EV_UNCHANGED, idx: lv ? lg : '0, hand: hand_r, last: 1'b1};
          end else if (found) begin
            if (lv && int'(lg) == int'(found_idx)) begin
              q0 <= '{kind: EV_UNCHANGED, idx: GIDX_W'(found_idx), hand: hand_r,
                      last: 1'b1};
            end else begin
              if (lv) begin
                q0    <= '{kind: EV_ENDED, idx: lg, hand: hand_r, last: 1'b0};
                q1    <= '{kind: EV_STARTED, idx: GIDX_W'(found_idx), hand: hand_r,
                           last: 1'b1};
                q_cnt <= 2'd2;
              end else begin
                q0 <= '{kind: EV_STARTED, idx: GIDX_W'(found_idx), hand: hand_r,
                        last: 1'b1};
              end
              last_g[hand_r] <= GIDX_W'(found_idx);
              last_v[hand_r] <= 1'b1;
            end
          end else if (lv) begin
            q0             <= '{kind: EV_ENDED, idx: lg, hand: hand_r, last: 1'b1};
            last_g[hand_r] <= '0;
            last_v[hand_r] <= 1'b0;
          end else begin
            q0 <= '{kind: EV_UNCHANGED, idx: '0, hand: hand_r, last: 1'b1};
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            q0    <= q1;
            q_cnt <= q_cnt - 1'b1;
            if (q_cnt == 2'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {1'b0, out_r.hand, out_r.idx};
  assign m_axis_tuser = out_r.kind;
  assign m_axis_tlast = out_r.last;

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (q_cnt == 2'd0))
    else $error("result queue not empty in idle");

  a_classify_busy: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tuser == CMD_CLASSIFY) |=> !s_axis_tready)
    else $error("ready after classify accept");

  a_first_is_ended: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == EV_ENDED))
    else $error("non-final result is not an ended event");

  a_started_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == EV_STARTED) |-> m_axis_tlast)
    else $error("started event not final");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (int'(ptr) <= MAX_GESTURES))
    else $error("scan pointer overrun");

endmodule
`default_nettype wire

[verif/gesture_event_checker.sv]
`timescale 1ns / 1ps
module gesture_event_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // hand, curls_packed, splays_packed, has_splays, full_tracking, entry_index,
  // slot_index, slot_value, slot_tolerance, entry_curl_only, zero pad
  input  logic [103:0] s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // gesture_index, event_hand, zero pad
  input  logic [7:0]   m_axis_tdata,
  // event_kind
  input  logic [1:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_count,
  output int           outstanding
);
  import hpgm_pkg::*;

  logic [7:0]        tmpl_ref [MAX_GESTURES][SLOTS];
  logic [7:0]        tmpl_tol [MAX_GESTURES][SLOTS];
  bit                tmpl_curl_only [MAX_GESTURES];
  bit                tmpl_on [MAX_GESTURES];
  logic [GIDX_W-1:0] held_gesture [2] = '{default: '0};
  bit                gesture_held [2];
  result_t           expected_events [$];
  int                mismatches = 0;

  function automatic bit in_band(logic [7:0] v, logic [7:0] r, logic [7:0] t);
    logic [7:0] d;
    d = (v >= r) ? v - r : r - v;
    return d <= t;
  endfunction

  function automatic bit template_fits(int e, logic [39:0] curls, logic [31:0] splays,
                                       logic has_sp);
    for (int i = 0; i < FINGER_COUNT; i++)
      if (!in_band(curls[8*i +: 8], tmpl_ref[e][i], tmpl_tol[e][i])) return 1'b0;
    if (!tmpl_curl_only[e] && has_sp)
      for (int i = 0; i < SPLAY_COUNT; i++)
        if (!in_band(splays[8*i +: 8], tmpl_ref[e][FINGER_COUNT+i],
                     tmpl_tol[e][FINGER_COUNT+i])) return 1'b0;
    return 1'b1;
  endfunction

  task automatic expect_event(logic [1:0] kind, logic [GIDX_W-1:0] idx, logic hand,
                              logic last);
    result_t ev;
    ev.kind = kind;
    ev.idx  = idx;
    ev.hand = hand;
    ev.last = last;
    expected_events.push_back(ev);
  endtask

  task automatic classify_pose(logic hand, logic [39:0] curls, logic [31:0] splays,
                               logic has_sp, logic full);
    int hit;
    bit any_on;
    hit = -1;
    any_on = 1'b0;
    for (int e = 0; e < MAX_GESTURES && hit < 0; e++) begin
      if (tmpl_on[e]) begin
        any_on = 1'b1;
        if ((tmpl_curl_only[e] || full) && template_fits(e, curls, splays, has_sp))
          hit = e;
      end
    end
    if (!any_on) begin
      expect_event(EV_UNCHANGED, gesture_held[hand] ? held_gesture[hand] : '0, hand, 1'b1);
    end else if (hit >= 0) begin
      if (gesture_held[hand] && held_gesture[hand] == GIDX_W'(hit)) begin
        expect_event(EV_UNCHANGED, GIDX_W'(hit), hand, 1'b1);
      end else begin
        if (gesture_held[hand]) expect_event(EV_ENDED, held_gesture[hand], hand, 1'b0);
        expect_event(EV_STARTED, GIDX_W'(hit), hand, 1'b1);
        held_gesture[hand] = GIDX_W'(hit);
        gesture_held[hand] = 1'b1;
      end
    end else if (gesture_held[hand]) begin
      expect_event(EV_ENDED, held_gesture[hand], hand, 1'b1);
      held_gesture[hand] = '0;
      gesture_held[hand] = 1'b0;
    end else begin
      expect_event(EV_UNCHANGED, '0, hand, 1'b1);
    end
  endtask

  task automatic take_command(logic [1:0] cmd, logic [103:0] d);
    logic [5:0] entry;
    logic [3:0] slot;
    entry = d[80:75];
    slot  = d[84:81];
    case (cmd)
      CMD_WRITE: begin
        if (entry < MAX_GESTURES && slot < SLOTS) begin
          tmpl_ref[entry][slot] = d[92:85];
          tmpl_tol[entry][slot] = d[100:93];
        end
      end
      CMD_VALIDATE: begin
        if (entry < MAX_GESTURES) begin
          tmpl_on[entry] = 1'b1;
          tmpl_curl_only[entry] = d[101];
        end
      end
      CMD_CLEAR: begin
        tmpl_on = '{default: 1'b0};
      end
      default: begin
        classify_pose(d[0], d[40:1], d[72:41], d[73], d[74]);
      end
    endcase
  endtask

  task automatic check_event();
    result_t got;
    result_t want;
    got.kind = m_axis_tuser;
    got.idx  = m_axis_tdata[GIDX_W-1:0];
    got.hand = m_axis_tdata[GIDX_W];
    got.last = m_axis_tlast;
    if (expected_events.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected event: kind %0d index %0d hand %0d last %0d",
                 got.kind, got.idx, got.hand, got.last);
      mismatches++;
    end else begin
      want = expected_events.pop_front();
      if (got.kind !== want.kind || got.idx !== want.idx || got.hand !== want.hand ||
          got.last !== want.last) begin
        if (mismatches < 10)
          $display("event mismatch: expected kind %0d index %0d hand %0d last %0d, %s %0d %0d %0d %0d",
                   want.kind, want.idx, want.hand, want.last, "got",
                   got.kind, got.idx, got.hand, got.last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_event();
      if (s_axis_tvalid && s_axis_tready) take_command(s_axis_tuser, s_axis_tdata);
    end
    fail_count  <= mismatches;
    outstanding <= expected_events.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import hpgm_pkg::*;

  localparam int ITEMS       = 1200;
  localparam int CYCLE_LIMIT = 1000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = CMD_WRITE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int sent = 0;
  bit tx_eager = 1'b0;
  bit rx_eager = 1'b0;

  logic [7:0]       shadow_ref [MAX_GESTURES][SLOTS];
  logic [7:0]       shadow_tol [MAX_GESTURES][SLOTS];
  bit [SLOTS-1:0]   slot_done [MAX_GESTURES];
  bit               shadow_on [MAX_GESTURES];

  hand_pose_gesture_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  gesture_event_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // after each taken item, hold tready low for a random stall, or not at all in eager mode
  initial begin : event_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        if ($urandom_range(0, 39) == 0) rx_eager = !rx_eager;
        stall = rx_eager ? 0 : int'($urandom_range(0, 14));
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [103:0] noise();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return {2'b00, r[101:0]};
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [103:0] d);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_eager = !tx_eager;
    gap = tx_eager ? 0 : int'($urandom_range(0, 14));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic write_slot(int e, int s, logic [7:0] v, logic [7:0] t);
    logic [103:0] d;
    d = noise();
    d[80:75]  = 6'(e);
    d[84:81]  = 4'(s);
    d[92:85]  = v;
    d[100:93] = t;
    send_item(CMD_WRITE, d);
    if (s < SLOTS) begin
      shadow_ref[e][s] = v;
      shadow_tol[e][s] = t;
      slot_done[e][s]  = 1'b1;
    end
  endtask

  task automatic validate_entry(int e, logic curl_only);
    logic [103:0] d;
    d = noise();
    d[80:75] = 6'(e);
    d[101]   = curl_only;
    send_item(CMD_VALIDATE, d);
    shadow_on[e] = 1'b1;
  endtask

  task automatic clear_table();
    send_item(CMD_CLEAR, noise());
    shadow_on = '{default: 1'b0};
  endtask

  task automatic send_pose(logic hand, logic [39:0] curls, logic [31:0] splays,
                           logic has_sp, logic full);
    logic [103:0] d;
    d = noise();
    d[0]     = hand;
    d[40:1]  = curls;
    d[72:41] = splays;
    d[73]    = has_sp;
    d[74]    = full;
    send_item(CMD_CLASSIFY, d);
  endtask

  task automatic program_entry(int e);
    int style;
    logic [7:0] t;
    style = int'($urandom_range(0, 3));
    for (int s = 0; s < SLOTS; s++) begin
      case (style)
        0:       t = 8'($urandom_range(0, 24));
        1:       t = 8'($urandom_range(0, 255));
        2:       t = $urandom_range(0, 1) ? 8'd0 : 8'd255;
        default: t = 8'($urandom_range(0, 60));
      endcase
      write_slot(e, s, 8'($urandom), t);
    end
    validate_entry(e, 1'($urandom_range(0, 1)));
  endtask

  // pose inside every band of entry e; with spoil set, one value is pushed out if its band leaves room
  task automatic pose_near(int e, bit spoil);
    logic [7:0] v [SLOTS];
    int lo, hi, bad;
    bad = spoil ? int'($urandom_range(0, SLOTS - 1)) : -1;
    for (int s = 0; s < SLOTS; s++) begin
      lo = int'(shadow_ref[e][s]) - int'(shadow_tol[e][s]);
      hi = int'(shadow_ref[e][s]) + int'(shadow_tol[e][s]);
      if (lo < 0) lo = 0;
      if (hi > 255) hi = 255;
      if (s == bad && lo > 0) v[s] = 8'($urandom_range(lo - 1, 0));
      else if (s == bad && hi < 255) v[s] = 8'($urandom_range(255, hi + 1));
      else v[s] = 8'($urandom_range(hi, lo));
    end
    send_pose(1'($urandom_range(0, 1)), {v[4], v[3], v[2], v[1], v[0]},
              {v[8], v[7], v[6], v[5]}, 1'($urandom_range(0, 1)),
              $urandom_range(0, 3) != 0);
  endtask

  task automatic classify_random();
    int on [$];
    int pick;
    for (int e = 0; e < MAX_GESTURES; e++)
      if (shadow_on[e]) on.push_back(e);
    pick = int'($urandom_range(0, 9));
    if (on.size() == 0 || pick < 2)
      send_pose(1'($urandom_range(0, 1)), 40'({$urandom, $urandom}), $urandom,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else
      pose_near(on[$urandom_range(0, on.size() - 1)], pick == 2);
  endtask

  initial begin : stimulus
    int start;
    int pick;
    int ready [$];
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_pose(1'b0, 40'({$urandom, $urandom}), $urandom, 1'b1, 1'b1);
    for (int s = 0; s < SLOTS; s++) begin
      if (s == 0) write_slot(63, s, 8'd0, 8'd255);
      else if (s < FINGER_COUNT) write_slot(63, s, 8'd128, 8'd10);
      else write_slot(63, s, 8'd255, 8'd0);
    end
    write_slot(63, 15, 8'd0, 8'd0);
    validate_entry(63, 1'b0);
    send_pose(1'b0, {{4{8'd128}}, 8'd0}, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_pose(1'b0, {{4{8'd138}}, 8'd0}, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_pose(1'b0, {{4{8'd138}}, 8'd0}, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_pose(1'b0, {{4{8'd138}}, 8'd0}, 32'hFFFF_FFFE, 1'b1, 1'b1);
    send_pose(1'b0, {{4{8'd118}}, 8'hFF}, 32'h0000_0000, 1'b0, 1'b1);
    send_pose(1'b0, {8'd128, 8'd128, 8'd128, 8'd117, 8'd5}, 32'hFFFF_FFFF, 1'b1, 1'b1);
    validate_entry(63, 1'b1);
    send_pose(1'b1, {{4{8'd128}}, 8'd0}, 32'h0000_0000, 1'b1, 1'b0);
    clear_table();
    send_pose(1'b1, 40'({$urandom, $urandom}), $urandom, 1'b1, 1'b1);
    send_pose(1'b0, 40'({$urandom, $urandom}), $urandom, 1'b1, 1'b1);

    start = sent;
    while (sent - start < ITEMS) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 8) begin
        program_entry(int'($urandom_range(0, MAX_GESTURES - 1)));
      end else if (pick < 14) begin
        write_slot(int'($urandom_range(0, MAX_GESTURES - 1)), int'($urandom_range(0, 15)),
                   8'($urandom), 8'($urandom));
      end else if (pick < 18) begin
        ready.delete();
        for (int e = 0; e < MAX_GESTURES; e++)
          if (&slot_done[e]) ready.push_back(e);
        if (ready.size() > 0)
          validate_entry(ready[$urandom_range(0, ready.size() - 1)],
                         1'($urandom_range(0, 1)));
      end else if (pick < 20) begin
        clear_table();
      end else begin
        classify_random();
      end
    end
    s_axis_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
